[rtl/sadrf_pkg.sv]
// Package for the slot allocator with dirty-run flush.
// Holds sizes, command and status codes, the controller states and the result record.
// Depends on nothing; sadrf_ctrl and the top level import it.
`default_nettype none

package sadrf_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int MAX_RUNS   = 32;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int RUNS_W = $clog2(MAX_RUNS + 1);

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int SIDX_W   = 6;
    localparam int STATUS_W = 4;
    localparam int SLOTF_W  = 6;
    localparam int RLEN_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_MARK    = 3'd2,
        CMD_FLUSH   = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT          = 4'd0,
        STAT_ALLOCATED    = 4'd1,
        STAT_FULL         = 4'd2,
        STAT_RELEASED     = 4'd3,
        STAT_RELEASE_MISS = 4'd4,
        STAT_MARKED       = 4'd5,
        STAT_RUN          = 4'd6,
        STAT_NOTHING      = 4'd7,
        STAT_CLEARED      = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_POP,
        S_ALLOC,
        S_FLUSH,
        S_EMIT
    } fsm_t;

    typedef struct packed {
        status_t              status;
        logic [SLOTF_W-1:0]   slot;
        logic [SLOTF_W-1:0]   run_base;
        logic [RLEN_W-1:0]    run_length;
        logic                 last;
    } result_t;

    function automatic result_t mk_result(
        input status_t            st,
        input logic [SLOTF_W-1:0] slot,
        input logic [SLOTF_W-1:0] start,
        input logic [RLEN_W-1:0]  len,
        input logic               last
    );
        result_t r;
        r.status     = st;
        r.slot       = slot;
        r.run_base   = start;
        r.run_length = len;
        r.last       = last;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/sadrf_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the key store and the free-slot stack; no package dependencies.
`default_nettype none

module sadrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/sadrf_ctrl.sv]
// Command sequencer of the slot allocator: key search, allocation, release and flush scan.
// Depends on sadrf_pkg and instantiates two sadrf_ram memories.
`default_nettype none

module sadrf_ctrl import sadrf_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [SIDX_W-1:0]   slot_index,
    output      logic                res_valid,
    input  wire logic                res_ready,
    output      result_t             res
);

    // Control state.
    fsm_t                   state_reg, state_next;
    logic [SLOT_COUNT-1:0]  valid_reg, valid_next;
    logic [SLOT_COUNT-1:0]  dirty_reg, dirty_next;
    logic [CNT_W-1:0]       free_count_reg, free_count_next;
    logic [CNT_W-1:0]       hw_reg, hw_next;
    logic                   any_dirty_reg, any_dirty_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic                   hit_reg, hit_next;
    logic                   in_run_reg, in_run_next;
    logic [RUNS_W-1:0]      run_count_reg, run_count_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   rest_reg, rest_next;
    logic                   ret_flush_reg, ret_flush_next;

    // Payload registers.
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [SLOT_W-1:0]      alloc_slot_reg, alloc_slot_next;
    logic [SLOT_W-1:0]      start_reg, start_next;
    logic [SLOT_W-1:0]      pend_start_reg, pend_start_next;
    logic [CNT_W-1:0]       pend_len_reg, pend_len_next;
    result_t                res_reg, res_next;

    // Memory ports.
    logic                   key_we, key_re;
    logic [SLOT_W-1:0]      key_waddr, key_raddr;
    logic [KEY_W-1:0]       key_rdata;
    logic                   free_we, free_re;
    logic [SLOT_W-1:0]      free_waddr, free_raddr;
    logic [SLOT_W-1:0]      free_rdata;

    logic [SLOT_W-1:0]      mark_idx;
    logic [SLOT_W-1:0]      scan_idx;
    logic [CNT_W-1:0]       run_len;
    logic                   scan_end;
    logic                   scan_dirty;
    logic                   idx_in_table;

    sadrf_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    sadrf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (hit_idx_reg),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    assign mark_idx     = SLOT_W'(slot_index);
    assign scan_idx     = idx_reg[SLOT_W-1:0];
    assign run_len      = idx_reg - CNT_W'(start_reg);
    assign scan_end     = (idx_reg == hw_reg);
    assign scan_dirty   = dirty_reg[scan_idx];
    assign idx_in_table = (idx_reg < CNT_W'(SLOT_COUNT));

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        free_count_next = free_count_reg;
        hw_next         = hw_reg;
        any_dirty_next  = any_dirty_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        hit_next        = hit_reg;
        in_run_next     = in_run_reg;
        run_count_next  = run_count_reg;
        pend_valid_next = pend_valid_reg;
        rest_next       = rest_reg;
        ret_flush_next  = ret_flush_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        alloc_slot_next = alloc_slot_reg;
        start_next      = start_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        res_next        = res_reg;

        key_we     = 1'b0;
        key_re     = 1'b0;
        key_waddr  = alloc_slot_reg;
        key_raddr  = scan_idx;
        free_we    = 1'b0;
        free_re    = 1'b0;
        free_waddr = SLOT_W'(free_count_reg);
        free_raddr = SLOT_W'(free_count_reg - CNT_W'(1));

        case (state_reg)
            S_IDLE:
            begin
                ret_flush_next = 1'b0;
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_LOOKUP, CMD_RELEASE:
                        begin
                            cmd_next       = cmd_t'(command);
                            key_next       = key;
                            idx_next       = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = S_SEARCH;
                        end
                        CMD_MARK:
                        begin
                            if (int'(slot_index) < SLOT_COUNT)
                            begin
                                dirty_next[mark_idx] = 1'b1;
                                any_dirty_next       = 1'b1;
                            end
                            res_next   = mk_result(STAT_MARKED, slot_index, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                        CMD_FLUSH:
                        begin
                            if (!any_dirty_reg || (hw_reg == '0))
                            begin
                                res_next   = mk_result(STAT_NOTHING, '0, '0, '0, 1'b1);
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                idx_next        = '0;
                                in_run_next     = 1'b0;
                                run_count_next  = '0;
                                pend_valid_next = 1'b0;
                                rest_next       = 1'b0;
                                state_next      = S_FLUSH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            valid_next      = '0;
                            dirty_next      = '0;
                            free_count_next = '0;
                            hw_next         = '0;
                            any_dirty_next  = 1'b0;
                            res_next   = mk_result(STAT_CLEARED, '0, '0, '0, 1'b1);
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // One key read is issued per cycle; its compare happens in the next cycle.
                key_re         = idx_in_table;
                cmp_valid_next = idx_in_table;
                cmp_idx_next   = scan_idx;
                if (idx_in_table)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && (key_rdata == key_reg))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        state_next   = S_DECIDE;
                    end
                    else if (cmp_idx_reg == SLOT_W'(SLOT_COUNT - 1))
                    begin
                        hit_next   = 1'b0;
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                if (cmd_reg == CMD_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        res_next   = mk_result(STAT_HIT, SLOTF_W'(hit_idx_reg), '0, '0, 1'b1);
                        state_next = S_EMIT;
                    end
                    else if (free_count_reg != '0)
                    begin
                        free_re         = 1'b1;
                        free_count_next = free_count_reg - CNT_W'(1);
                        state_next      = S_POP;
                    end
                    else if (hw_reg < CNT_W'(SLOT_COUNT))
                    begin
                        alloc_slot_next = SLOT_W'(hw_reg);
                        hw_next         = hw_reg + CNT_W'(1);
                        state_next      = S_ALLOC;
                    end
                    else
                    begin
                        res_next   = mk_result(STAT_FULL, '0, '0, '0, 1'b1);
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        if (free_count_reg < CNT_W'(SLOT_COUNT))
                        begin
                            free_we         = 1'b1;
                            free_count_next = free_count_reg + CNT_W'(1);
                        end
                        valid_next[hit_idx_reg] = 1'b0;
                        res_next = mk_result(STAT_RELEASED, SLOTF_W'(hit_idx_reg), '0, '0,
                                             1'b1);
                    end
                    else
                    begin
                        res_next = mk_result(STAT_RELEASE_MISS, '0, '0, '0, 1'b1);
                    end
                    state_next = S_EMIT;
                end
            end

            S_POP:
            begin
                alloc_slot_next = free_rdata;
                state_next      = S_ALLOC;
            end

            S_ALLOC:
            begin
                key_we                     = 1'b1;
                valid_next[alloc_slot_reg] = 1'b1;
                dirty_next[alloc_slot_reg] = 1'b1;
                any_dirty_next             = 1'b1;
                res_next   = mk_result(STAT_ALLOCATED, SLOTF_W'(alloc_slot_reg), '0, '0, 1'b1);
                state_next = S_EMIT;
            end

            S_FLUSH:
            begin
                if (in_run_reg)
                begin
                    if (!scan_end && scan_dirty)
                    begin
                        dirty_next[scan_idx] = 1'b0;
                        idx_next             = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // The run just closed is held back until it is known
                        // whether another run follows it.
                        in_run_next    = 1'b0;
                        run_count_next = run_count_reg + RUNS_W'(1);
                        if (pend_valid_reg)
                        begin
                            res_next = mk_result(STAT_RUN, '0, SLOTF_W'(pend_start_reg),
                                                 RLEN_W'(pend_len_reg), 1'b0);
                            ret_flush_next = 1'b1;
                            state_next     = S_EMIT;
                        end
                        pend_valid_next = 1'b1;
                        pend_start_next = start_reg;
                        pend_len_next   = run_len;
                    end
                end
                else if (scan_end)
                begin
                    any_dirty_next = rest_reg;
                    ret_flush_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        res_next = mk_result(STAT_RUN, '0, SLOTF_W'(pend_start_reg),
                                             RLEN_W'(pend_len_reg), 1'b1);
                    end
                    else
                    begin
                        res_next = mk_result(STAT_NOTHING, '0, '0, '0, 1'b1);
                    end
                    state_next = S_EMIT;
                end
                else if (run_count_reg == RUNS_W'(MAX_RUNS))
                begin
                    // Run limit reached: only look for marks left pending.
                    rest_next = rest_reg | scan_dirty;
                    idx_next  = idx_reg + CNT_W'(1);
                end
                else if (scan_dirty)
                begin
                    start_next           = scan_idx;
                    in_run_next          = 1'b1;
                    dirty_next[scan_idx] = 1'b0;
                    idx_next             = idx_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ret_flush_reg ? S_FLUSH : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            free_count_reg <= '0;
            hw_reg         <= '0;
            any_dirty_reg  <= 1'b0;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            in_run_reg     <= 1'b0;
            run_count_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rest_reg       <= 1'b0;
            ret_flush_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            free_count_reg <= free_count_next;
            hw_reg         <= hw_next;
            any_dirty_reg  <= any_dirty_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            hit_reg        <= hit_next;
            in_run_reg     <= in_run_next;
            run_count_reg  <= run_count_next;
            pend_valid_reg <= pend_valid_next;
            rest_reg       <= rest_next;
            ret_flush_reg  <= ret_flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        alloc_slot_reg <= alloc_slot_next;
        start_reg      <= start_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

[rtl/slot_allocator_dirty_run_flush_top.sv]
// Top level of the slot allocator with dirty-run flush.
// Depends on sadrf_pkg and instantiates sadrf_ctrl; holds the output register.
//
//   Channel   Direction  Handshake          Payload
//   input     in         in_valid/in_stall  command, key, slot_index
//   output    out        out_valid/out_stall status, slot, run_base, run_length, last
//
// One item is worked on at a time. A lookup or release walks the key memory one
// entry per cycle, so a lookup that takes its slot from the free stack walks the
// whole memory and then passes through S_DECIDE, S_POP, S_ALLOC and S_EMIT.
// Mark and clear go from S_IDLE straight to S_EMIT. A flush scans the slots below
// the high-water mark one at a time and passes through S_EMIT for each emitted run.
// Reset clears all control state at once; the key and free-stack memories need no
// clearing pass. A stalled output holds its result while the sequencer waits.
`default_nettype none

module slot_allocator_dirty_run_flush_top import sadrf_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_stall,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [KEY_W-1:0]    key,
    input  wire logic [SIDX_W-1:0]   slot_index,
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      logic [STATUS_W-1:0] status,
    output      logic [SLOTF_W-1:0]  slot,
    output      logic [SLOTF_W-1:0]  run_base,
    output      logic [RLEN_W-1:0]   run_length,
    output      logic                last
);

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg;
    result_t out_reg;

    sadrf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .slot_index (slot_index),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The output register takes a new result whenever it is empty or its
    // current result is being transferred in this cycle.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign slot       = out_reg.slot;
    assign run_base   = out_reg.run_base;
    assign run_length = out_reg.run_length;
    assign last       = out_reg.last;

endmodule

`default_nettype wire
